// File: rtl/core/sba_pkg.sv
// Shared constants, codes and the result record of the LIFO stack allocator.
// Used by the top level, its port checker and the testbench; depends on nothing else.
package sba_pkg;

	localparam int MAX_BLOCKS   = 64;
	localparam int HEADER_BYTES = 4;
	localparam int ADDR_BITS    = 20;

	localparam int FIELD_W   = 21;
	localparam int SUM_W     = FIELD_W + 1;
	localparam int FIT_W     = FIELD_W + 2;
	localparam int ALIGN_W   = 3;
	localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);
	localparam int IDX_W     = $clog2(MAX_BLOCKS);
	localparam int CFG_IDX_W = 1;

	localparam logic [ALIGN_W-1:0] ALIGN_MAX   = ALIGN_W'(6);
	localparam logic [ALIGN_W-1:0] ALIGN_RESET = ALIGN_W'(3);
	localparam logic [FIELD_W-1:0] POOL_RESET  = FIELD_W'(65536);
	localparam logic [FIELD_W-1:0] POOL_CAP    = FIELD_W'(1) << ADDR_BITS;

	// request codes
	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE  = 2'd1;
	localparam logic [1:0] REQ_RESET = 2'd2;
	localparam logic [1:0] REQ_NONE  = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_SPACE  = 2'd1;
	localparam logic [1:0] ST_BAD_FREE  = 2'd2;
	localparam logic [1:0] ST_STK_FULL  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_LOG2 = CFG_IDX_W'(1);

	typedef struct packed {
		logic [1:0]         status;
		logic [FIELD_W-1:0] payload_offset;
		logic [FIELD_W-1:0] used_bytes;
	} result_t;

endpackage

// File: rtl/core/stack_bump_allocator_unit.sv
// LIFO stack allocator: one request in, one result out, every cycle while the
// two-entry result queue has room. Each result is registered into that queue
// when its item is accepted and leaves in order; the queue absorbs output stalls.
// The top block start sits in a register; older starts live in a 64-entry memory
// whose next entry down is prefetched, so a free never waits on the read port.
// Reset (arst_n low, async) empties the pool and the result queue, and loads
// pool_size 65536 and align_log2 3. No clearing pass is needed.
module stack_bump_allocator_unit
	import sba_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           req_type,
	input  logic [FIELD_W-1:0]   alloc_size,
	input  logic [FIELD_W-1:0]   free_offset,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic [FIELD_W-1:0]   payload_offset,
	output logic [FIELD_W-1:0]   used_bytes,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FIELD_W-1:0]   cfg_data
);

	logic [FIELD_W-1:0] pool_q;
	logic [ALIGN_W-1:0] align_q;
	logic [FIELD_W-1:0] top_q;
	logic [CNT_W-1:0]   live_q;
	logic [FIELD_W-1:0] top_start_q;   // start of the newest live block
	logic [FIELD_W-1:0] below_q;       // start of the block under it
	logic [FIELD_W-1:0] starts_mem [MAX_BLOCKS];

	result_t            slot_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         cnt_q;

	logic               in_fire;
	logic               out_fire;
	logic               push;
	logic               pop;
	logic [FIELD_W-1:0] nxt_top;
	logic [CNT_W-1:0]   nxt_live;
	result_t            res;
	logic [CNT_W-1:0]   live_m1;
	logic [CNT_W-1:0]   live_m3;

	logic [ALIGN_W-1:0] sh;
	logic [SUM_W-1:0]   amask;
	logic [SUM_W-1:0]   raw;
	logic [SUM_W-1:0]   total;
	logic [FIELD_W-1:0] limit;
	logic [FIT_W-1:0]   fit_sum;
	logic               fits;
	logic               stk_full;
	logic [FIELD_W-1:0] top_payload;

	assign cfg_ready = 1'b1;
	assign in_stall  = (cnt_q == 2'd2);
	assign in_fire   = in_valid & ~in_stall;
	assign out_valid = (cnt_q != 2'd0);
	assign out_fire  = out_valid & ~out_stall;
	assign live_m1   = live_q - CNT_W'(1);
	assign live_m3   = live_q - CNT_W'(3);

	assign status         = slot_q[rd_ptr_q].status;
	assign payload_offset = slot_q[rd_ptr_q].payload_offset;
	assign used_bytes     = slot_q[rd_ptr_q].used_bytes;

	always_comb begin
		sh          = (align_q > ALIGN_MAX) ? ALIGN_MAX : align_q;
		amask       = (SUM_W'(1) << sh) - SUM_W'(1);
		raw         = {1'b0, alloc_size} + SUM_W'(HEADER_BYTES);
		total       = (raw + amask) & ~amask;
		limit       = (pool_q > POOL_CAP) ? POOL_CAP : pool_q;
		fit_sum     = {2'b00, top_q} + {1'b0, total};
		fits        = (fit_sum <= {2'b00, limit});
		stk_full    = (live_q == CNT_W'(MAX_BLOCKS));
		top_payload = top_start_q + FIELD_W'(HEADER_BYTES);

		push               = 1'b0;
		pop                = 1'b0;
		nxt_top            = top_q;
		nxt_live           = live_q;
		res.status         = ST_OK;
		res.payload_offset = '0;

		unique case (req_type)
			REQ_ALLOC: begin
				if (stk_full) begin
					res.status = ST_STK_FULL;
				end else if (!fits) begin
					res.status = ST_NO_SPACE;
				end else begin
					push               = 1'b1;
					res.payload_offset = top_q + FIELD_W'(HEADER_BYTES);
					nxt_top            = fit_sum[FIELD_W-1:0];
					nxt_live           = live_q + CNT_W'(1);
				end
			end
			REQ_FREE: begin
				if (live_q != '0 && top_payload == free_offset) begin
					pop      = 1'b1;
					nxt_top  = top_start_q;
					nxt_live = live_m1;
				end else begin
					res.status = ST_BAD_FREE;
				end
			end
			REQ_RESET: begin
				nxt_top  = '0;
				nxt_live = '0;
			end
			REQ_NONE: begin
			end
			default: begin
			end
		endcase

		res.used_bytes = nxt_top;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q  <= POOL_RESET;
			align_q <= ALIGN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_POOL_SIZE:  pool_q  <= cfg_data;
				CFG_ALIGN_LOG2: align_q <= cfg_data[ALIGN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q  <= '0;
			live_q <= '0;
		end else if (in_fire) begin
			top_q  <= nxt_top;
			live_q <= nxt_live;
		end
	end

	// block start stack: newest in top_start_q, next in below_q, rest in memory
	always_ff @(posedge clk) begin
		if (in_fire && push) begin
			top_start_q <= top_q;
			below_q     <= top_start_q;
			if (live_q != '0) begin
				starts_mem[live_m1[IDX_W-1:0]] <= top_start_q;
			end
		end else if (in_fire && pop) begin
			top_start_q <= below_q;
			below_q     <= starts_mem[live_m3[IDX_W-1:0]];
		end
	end

	// two-entry result queue
	always_ff @(posedge clk) begin
		if (in_fire) begin
			slot_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (in_fire) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (out_fire) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, in_fire} - {1'b0, out_fire};
		end
	end

endmodule

// File: rtl/core/sba_checker.sv
// Port-level checks for the stack allocator top level, bound onto it below.
// Depends on sba_pkg for field widths and status codes.
module sba_port_checks
	import sba_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [1:0]           status,
	input logic [FIELD_W-1:0]   payload_offset,
	input logic [FIELD_W-1:0]   used_bytes
);

	// a held result item stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) &&
		$stable(payload_offset) && $stable(used_bytes))
		else $error("stalled result item changed");

	// input backs up only behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

	// only a good allocate carries a payload offset
	a_payload_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> payload_offset == '0)
		else $error("payload offset on failed request");

	// a new block lies below the new top
	a_payload_below_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && payload_offset != '0 |-> payload_offset <= used_bytes)
		else $error("payload offset above used bytes");

endmodule

bind stack_bump_allocator_unit sba_port_checks u_sba_port_checks (.*);

// File: sim/sba_checker.sv
// Result checker for stack_bump_allocator_unit: watches the request, result and
// configuration channels, predicts every result and compares it field by field.
// Depends on sba_pkg for widths, codes and the result record.
module sba_checker
	import sba_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [1:0]           req_type,
	input  logic [FIELD_W-1:0]   alloc_size,
	input  logic [FIELD_W-1:0]   free_offset,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [1:0]           status,
	input  logic [FIELD_W-1:0]   payload_offset,
	input  logic [FIELD_W-1:0]   used_bytes,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FIELD_W-1:0]   cfg_data,
	output int                   outstanding,
	output int                   mismatches
);

	logic [FIELD_W-1:0] pool_reg;
	logic [ALIGN_W-1:0] align_reg;
	logic [FIELD_W-1:0] top_off;
	logic [FIELD_W-1:0] starts [MAX_BLOCKS];
	int                 live;
	result_t            awaited [$];

	// Applies one request to the predicted pool and returns its result.
	function automatic result_t serve_request(input logic [1:0] req,
			input logic [FIELD_W-1:0] size, input logic [FIELD_W-1:0] offs);
		int      shift;
		int      span;
		int      limit;
		result_t r;
		r.status = ST_OK;
		r.payload_offset = '0;
		shift = (align_reg > ALIGN_MAX) ? int'(ALIGN_MAX) : int'(align_reg);
		span = ((int'(size) + HEADER_BYTES + (1 << shift) - 1) >> shift) << shift;
		limit = (pool_reg > POOL_CAP) ? int'(POOL_CAP) : int'(pool_reg);
		case (req)
			REQ_ALLOC: begin
				// stack-full check wins over the space check
				if (live >= MAX_BLOCKS)
					r.status = ST_STK_FULL;
				else if (int'(top_off) + span > limit)
					r.status = ST_NO_SPACE;
				else begin
					starts[live] = top_off;
					live++;
					r.payload_offset = FIELD_W'(int'(top_off) + HEADER_BYTES);
					top_off = FIELD_W'(int'(top_off) + span);
				end
			end
			REQ_FREE: begin
				if (live > 0 && int'(starts[live-1]) + HEADER_BYTES == int'(offs)) begin
					live--;
					top_off = starts[live];
				end else
					r.status = ST_BAD_FREE;
			end
			REQ_RESET: begin
				top_off = '0;
				live = 0;
			end
			default: ;
		endcase
		r.used_bytes = top_off;
		return r;
	endfunction

	task automatic note_mismatch(input string what, input int want, input int got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			pool_reg = POOL_RESET;
			align_reg = ALIGN_RESET;
			top_off = '0;
			live = 0;
			awaited.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			// result first: it belongs to an item taken at an earlier edge
			if (out_valid && !out_stall) begin
				if (awaited.size() == 0)
					note_mismatch("unexpected result, used_bytes", -1, int'(used_bytes));
				else begin
					want = awaited.pop_front();
					if (status !== want.status)
						note_mismatch("status", int'(want.status), int'(status));
					if (payload_offset !== want.payload_offset)
						note_mismatch("payload_offset", int'(want.payload_offset),
							int'(payload_offset));
					if (used_bytes !== want.used_bytes)
						note_mismatch("used_bytes", int'(want.used_bytes), int'(used_bytes));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_POOL_SIZE:  pool_reg = cfg_data;
					CFG_ALIGN_LOG2: align_reg = cfg_data[ALIGN_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				awaited.push_back(serve_request(req_type, alloc_size, free_offset));
			outstanding <= awaited.size();
		end
	end

endmodule

// File: sim/tb.sv
// Top of the allocator testbench: clock, reset, request and configuration
// stimulus, result-side stalls and the verdict. Needs sba_pkg, the allocator
// and sba_checker, which does all result prediction and comparison.
module tb;
	import sba_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [1:0]           req_type = REQ_NONE;
	logic [FIELD_W-1:0]   alloc_size = '0;
	logic [FIELD_W-1:0]   free_offset = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [1:0]           status;
	logic [FIELD_W-1:0]   payload_offset;
	logic [FIELD_W-1:0]   used_bytes;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_POOL_SIZE;
	logic [FIELD_W-1:0]   cfg_data = '0;
	int                   outstanding;
	int                   mismatches;

	int cycles = 0;
	int burst_left = 1;
	int stall_mode = 0;
	int stall_left = 0;

	// stimulus-side view of the stack, only used to aim frees at the top block
	int trk_limit = 65536;
	int trk_shift = 3;
	int trk_top = 0;
	int trk_starts [$];

	stack_bump_allocator_unit DUT (.*);
	sba_checker watch (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// result side: stretches of no stall, light, even and heavy stalling
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(8, 64);
		end else
			stall_left--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 1) == 0);
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	function automatic void track(input logic [1:0] req, input logic [FIELD_W-1:0] size,
			input logic [FIELD_W-1:0] offs);
		int span;
		span = ((int'(size) + HEADER_BYTES + (1 << trk_shift) - 1) >> trk_shift) << trk_shift;
		case (req)
			REQ_ALLOC:
				if (trk_starts.size() < MAX_BLOCKS && trk_top + span <= trk_limit) begin
					trk_starts.push_back(trk_top);
					trk_top += span;
				end
			REQ_FREE:
				if (trk_starts.size() > 0 && trk_starts[$] + HEADER_BYTES == int'(offs))
					trk_top = trk_starts.pop_back();
			REQ_RESET: begin
				trk_top = 0;
				trk_starts.delete();
			end
			default: ;
		endcase
	endfunction

	function automatic logic [FIELD_W-1:0] top_payload();
		if (trk_starts.size() == 0)
			return FIELD_W'($urandom());
		return FIELD_W'(trk_starts[$] + HEADER_BYTES);
	endfunction

	// mostly small blocks, now and then huge ones
	function automatic logic [FIELD_W-1:0] rand_size();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 12)
			return FIELD_W'($urandom_range(0, 64));
		if (pick < 17)
			return FIELD_W'($urandom_range(0, 4096));
		if (pick < 19)
			return FIELD_W'($urandom_range(0, 1 << 20));
		return FIELD_W'($urandom());
	endfunction

	// bursts of items with random gaps between them
	task automatic pace();
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
	endtask

	task automatic send(input logic [1:0] req, input logic [FIELD_W-1:0] size,
			input logic [FIELD_W-1:0] offs);
		in_valid <= 1'b1;
		req_type <= req;
		alloc_size <= size;
		free_offset <= offs;
		track(req, size, offs);
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pace();
	endtask

	// hold off until every predicted result has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_config(input logic [FIELD_W-1:0] pool, input logic [ALIGN_W-1:0] align);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_POOL_SIZE;
		cfg_data <= pool;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_index <= CFG_ALIGN_LOG2;
		cfg_data <= FIELD_W'(align);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		trk_limit = (pool > POOL_CAP) ? int'(POOL_CAP) : int'(pool);
		trk_shift = (align > ALIGN_MAX) ? int'(ALIGN_MAX) : int'(align);
	endtask

	task automatic random_item();
		int pick;
		logic [FIELD_W-1:0] offs;
		pick = $urandom_range(0, 99);
		if (pick < 45 || (pick < 80 && trk_starts.size() == 0))
			send(REQ_ALLOC, rand_size(), FIELD_W'($urandom()));
		else if (pick < 80)
			send(REQ_FREE, FIELD_W'($urandom()), top_payload());
		else if (pick < 90) begin
			case ($urandom_range(0, 2))
				0: offs = FIELD_W'($urandom());
				1: offs = top_payload() ^ (FIELD_W'(1) << $urandom_range(0, FIELD_W - 1));
				default: offs = (trk_starts.size() > 1)
					? FIELD_W'(trk_starts[$-1] + HEADER_BYTES) : FIELD_W'($urandom());
			endcase
			send(REQ_FREE, FIELD_W'($urandom()), offs);
		end else if (pick < 94)
			send(REQ_RESET, FIELD_W'($urandom()), FIELD_W'($urandom()));
		else
			send(REQ_NONE, FIELD_W'($urandom()), FIELD_W'($urandom()));
	endtask

	// push past the block stack limit, then unwind it all
	task automatic fill_stack();
		send(REQ_RESET, '0, '0);
		repeat (MAX_BLOCKS + 2)
			send(REQ_ALLOC, FIELD_W'($urandom_range(0, 3)), FIELD_W'($urandom()));
		while (trk_starts.size() > 0)
			send(REQ_FREE, FIELD_W'($urandom()), top_payload());
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed part, reset configuration: 64 KiB pool, 8-byte alignment
		send(REQ_FREE, '0, FIELD_W'(HEADER_BYTES));
		send(REQ_ALLOC, '0, '0);
		send(REQ_FREE, '0, top_payload());
		send(REQ_ALLOC, '1, '0);
		send(REQ_ALLOC, FIELD_W'(65536 - HEADER_BYTES), '0);
		send(REQ_ALLOC, '0, '0);
		send(REQ_FREE, '0, top_payload());
		send(REQ_ALLOC, FIELD_W'(1), '0);
		send(REQ_ALLOC, FIELD_W'(13), '1);
		send(REQ_FREE, '1, FIELD_W'(trk_starts[0] + HEADER_BYTES));
		send(REQ_FREE, '0, '1);
		send(REQ_NONE, '1, '1);
		send(REQ_RESET, '1, '1);
		send(REQ_FREE, '0, FIELD_W'(HEADER_BYTES));
		drain();
		// alignment code 7 acts as 64 bytes: one header-only block fills the pool
		set_config(FIELD_W'(64), 3'd7);
		send(REQ_ALLOC, '0, '0);
		send(REQ_ALLOC, '0, '0);
		send(REQ_FREE, '0, top_payload());
		send(REQ_FREE, '0, FIELD_W'(HEADER_BYTES));
		drain();
		set_config('0, 3'd0);
		send(REQ_ALLOC, '0, '0);

		// random part; the stack carries over config changes, so a shrunk pool
		// can sit below the current top
		for (int ph = 0; ph < 9; ph++) begin
			drain();
			case (ph)
				0: set_config(FIELD_W'(1 << 20), 3'd0);
				1: set_config('1, 3'd7);
				2: set_config(FIELD_W'(4096), 3'd2);
				3: set_config('0, 3'd5);
				4: set_config(FIELD_W'(300), 3'd6);
				5: set_config(FIELD_W'(65536), 3'd1);
				6: set_config(FIELD_W'((1 << 20) - 1), 3'd4);
				7: set_config(FIELD_W'(128), 3'd3);
				default: set_config(FIELD_W'(20000), 3'd5);
			endcase
			if (ph == 0 || ph == 6)
				fill_stack();
			repeat (40) random_item();
		end

		drain();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
